// File: src/assert_macros.svh
// Assertion macros shared by the pattern search RTL.
// Depends on nothing; included by modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("assertion failed");
// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

// File: src/mbps_pkg.sv
// Package for the masked byte pattern search unit: types, register indexes,
// widths. No dependencies.
`timescale 1ns / 1ps
package mbps_pkg;
	localparam int MAX_PATTERN_BYTES_DEF = 32;
	localparam int PatRegCount = 4;
	localparam int PatBytes = 32;
	localparam int CfgIdxW = 3;
	localparam int CfgDataW = 64;
	localparam int LenW = 6;

	localparam logic [CfgIdxW-1:0] RegPattern0 = 3'd0;
	localparam logic [CfgIdxW-1:0] RegPattern1 = 3'd1;
	localparam logic [CfgIdxW-1:0] RegPattern2 = 3'd2;
	localparam logic [CfgIdxW-1:0] RegPattern3 = 3'd3;
	localparam logic [CfgIdxW-1:0] RegCareMask = 3'd4;
	localparam logic [CfgIdxW-1:0] RegPatLength = 3'd5;
	localparam logic [CfgIdxW-1:0] RegOffset = 3'd6;

	typedef struct packed {
		logic [7:0]  data_byte;
		logic [31:0] byte_address;
		logic        region_end;
	} in_item_t;

	typedef struct packed {
		logic        found;
		logic [31:0] match_address;
	} out_item_t;

	typedef struct packed {
		logic [PatRegCount-1:0][CfgDataW-1:0] pattern_reg;
		logic [PatBytes-1:0]                   care_mask;
		logic [LenW-1:0]                       pattern_length;
		logic [31:0]                           result_offset;
	} mbps_cfg_t;
endpackage

// File: src/mbps_cfg_regs.sv
// Configuration register file of the pattern search unit.
// Depends on mbps_pkg.
`timescale 1ns / 1ps
module mbps_cfg_regs (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_wr_en,
	input  logic [mbps_pkg::CfgIdxW-1:0]   cfg_index,
	input  logic [mbps_pkg::CfgDataW-1:0]  cfg_data,
	output mbps_pkg::mbps_cfg_t            cfg
);
	import mbps_pkg::*;

	mbps_cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pattern_reg    <= '0;
			cfg_q.care_mask      <= '1;
			cfg_q.pattern_length <= LenW'(1);
			cfg_q.result_offset  <= '0;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				RegPattern0:  cfg_q.pattern_reg[0] <= cfg_data;
				RegPattern1:  cfg_q.pattern_reg[1] <= cfg_data;
				RegPattern2:  cfg_q.pattern_reg[2] <= cfg_data;
				RegPattern3:  cfg_q.pattern_reg[3] <= cfg_data;
				RegCareMask:  cfg_q.care_mask <= cfg_data[PatBytes-1:0];
				RegPatLength: cfg_q.pattern_length <= cfg_data[LenW-1:0];
				RegOffset:    cfg_q.result_offset <= cfg_data[31:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;
endmodule

// File: src/mbps_match_core.sv
// Byte window, region state and masked window compare for one transaction.
// Depends on mbps_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module mbps_match_core #(
	parameter int MaxBytes = mbps_pkg::MAX_PATTERN_BYTES_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  mbps_pkg::mbps_cfg_t  cfg,
	input  logic                 step,
	input  mbps_pkg::in_item_t   item,
	output logic                 res_valid,
	output mbps_pkg::out_item_t  res
);
	import mbps_pkg::*;

	localparam int SeenW = $clog2(MaxBytes + 1);
	localparam int IdxW = (MaxBytes > 1) ? $clog2(MaxBytes) : 1;

	logic [MaxBytes-1:0][7:0] win_q;
	logic [MaxBytes-1:0][7:0] win_next;
	logic [SeenW-1:0]         seen_q;
	logic [SeenW-1:0]         seen_next;
	logic                     reported_q;
	logic [SeenW-1:0]         len_eff;
	logic [MaxBytes-1:0]      pos_ok;
	logic                     zero_len;
	logic                     hit;
	logic [31:0]              start_addr;

	// window entry k: byte seen k transactions ago, 0 = current
	genvar k;
	generate
		for (k = 0; k < MaxBytes; k++) begin : g_shift
			if (k == 0) begin : g_head
				assign win_next[k] = item.data_byte;
			end else begin : g_tail
				assign win_next[k] = win_q[k-1];
			end
		end
	endgenerate

	assign seen_next = (seen_q == SeenW'(MaxBytes)) ? seen_q : seen_q + SeenW'(1);
	assign zero_len  = (cfg.pattern_length == '0);

	always_comb begin
		if (zero_len) begin
			len_eff = SeenW'(1);
		end else if (int'(cfg.pattern_length) > MaxBytes) begin
			len_eff = SeenW'(MaxBytes);
		end else begin
			len_eff = SeenW'(cfg.pattern_length);
		end
	end

	// position i of the pattern sits at window entry len-1-i
	genvar i;
	generate
		for (i = 0; i < MaxBytes; i++) begin : g_pos
			if (i < PatBytes) begin : g_cmp
				logic [IdxW-1:0] idx;
				logic            cares;
				assign idx   = IdxW'(int'(len_eff) - 1 - i);
				assign cares = cfg.care_mask[i] && (len_eff > SeenW'(i));
				assign pos_ok[i] = !cares ||
					(win_next[idx] == cfg.pattern_reg[i / 8][(i % 8) * 8 +: 8]);
			end else begin : g_wild
				assign pos_ok[i] = 1'b1;
			end
		end
	endgenerate

	assign hit = !reported_q && (zero_len || ((seen_next >= len_eff) && (&pos_ok)));
	assign start_addr = item.byte_address - 32'(len_eff) + 32'd1;

	assign res_valid         = !reported_q && (hit || item.region_end);
	assign res.found         = hit;
	assign res.match_address = hit ? (start_addr + cfg.result_offset) : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q     <= '0;
			reported_q <= 1'b0;
		end else if (step) begin
			if (item.region_end) begin
				seen_q     <= '0;
				reported_q <= 1'b0;
			end else if (!reported_q) begin
				seen_q     <= seen_next;
				reported_q <= hit;
			end
		end
	end

	// window contents are only read below the fill count
	always_ff @(posedge clk) begin
		if (step && !reported_q) begin
			win_q <= win_next;
		end
	end

	`ASSERT_NEXT(a_region_clear, clk, arst_n, step && item.region_end, seen_q == '0 && !reported_q)
	`ASSERT_IMPL(a_reported_seen, clk, arst_n, reported_q, seen_q != '0)
	`ASSERT_IMPL(a_seen_bound, clk, arst_n, 1'b1, seen_q <= SeenW'(MaxBytes))
	`ASSERT_IMPL(a_miss_zero, clk, arst_n, res_valid && !res.found, res.match_address == '0)
endmodule

// File: src/masked_byte_pattern_search_unit.sv
// Masked byte pattern search unit, top level.
// Depends on mbps_pkg, mbps_cfg_regs, mbps_match_core.
//
// Input channel in_valid/in_stall/in_data carries one region byte with its
// address and an end-of-region flag per transaction. Output channel
// out_valid/out_stall/out_data carries at most one result per region: the
// first match (found = 1, start address plus offset) or, when the final
// byte passes unmatched, found = 0 with address 0.
// Configuration: cfg_wr_en/cfg_index/cfg_data, to be written only while idle; the block itself does not enforce this.
// Timing: an input register, then the window compare and a result register,
// which captures the result when its byte leaves the input register. One byte
// per cycle is sustained while the receiver does not stall; the bound is the
// window update and compare, which feeds the match flag of the next byte.
// Reset clears the region state and loads register defaults (care mask all
// ones, length 1). When the receiver stalls, the result register holds; a
// byte already in the input register waits there, and in_stall is high while
// it waits.
`timescale 1ns / 1ps
module masked_byte_pattern_search_unit #(
	parameter int MaxPatternBytes = mbps_pkg::MAX_PATTERN_BYTES_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_wr_en,
	input  logic [mbps_pkg::CfgIdxW-1:0]   cfg_index,
	input  logic [mbps_pkg::CfgDataW-1:0]  cfg_data,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  mbps_pkg::in_item_t             in_data,
	output logic                           out_valid,
	input  logic                           out_stall,
	output mbps_pkg::out_item_t            out_data
);
	import mbps_pkg::*;

	mbps_cfg_t cfg;
	in_item_t  item_s1;
	logic      valid_s1;
	logic      step;
	logic      res_valid;
	out_item_t res;
	logic      out_valid_q;
	out_item_t out_data_q;

	mbps_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	assign step     = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			valid_s1 <= 1'b1;
		end else if (step) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_s1 <= in_data;
		end
	end

	mbps_match_core #(
		.MaxBytes (MaxPatternBytes)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.step      (step),
		.item      (item_s1),
		.res_valid (res_valid),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step) begin
			out_valid_q <= res_valid;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step && res_valid) begin
			out_data_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;
endmodule
